/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* src/clcg_pkg.sv */
// ----------------------------------------------------------------------------
// clcg_pkg
// Constants, types and controller states of the combined LCG shuffle generator.
// ----------------------------------------------------------------------------
`default_nettype none

package clcg_pkg;

    // Default shuffle table depth
    localparam int TABLE_SIZE_DEF = 32;

    // Generator moduli and multipliers
    localparam logic [30:0] MOD_ONE   = 31'd2147483563;
    localparam logic [30:0] MOD_TWO   = 31'd2147483393;
    localparam logic [15:0] MUL_ONE   = 16'd40014;
    localparam logic [15:0] MUL_TWO   = 16'd40692;

    // 2^31 mod each modulus, used to fold the product high part back in
    localparam logic [7:0]  FOLD_ONE  = 8'd85;
    localparam logic [7:0]  FOLD_TWO  = 8'd255;

    // Largest raw value, and largest fraction code
    localparam logic [30:0] RANGE_TOP = 31'd2147483562;
    localparam logic [23:0] FRAC_MAX  = 24'd16777214;

    // Generator pair control
    typedef struct packed {
        logic load;
        logic start;
        logic step_two;
    } t_gen_ctrl;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_ABS,
        S_LOAD,
        S_WGO,
        S_WARM,
        S_DRAW,
        S_SLOT,
        S_WAIT,
        S_FRAC,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

/* src/clcg_gen_pair.sv */
// ----------------------------------------------------------------------------
// clcg_gen_pair
// Both multiplicative generators with a three-stage multiply, fold, reduce path.
// ----------------------------------------------------------------------------
`default_nettype none

module clcg_gen_pair (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire clcg_pkg::t_gen_ctrl  i_ctrl,
    input  wire logic [30:0]          i_load_value,
    output logic [30:0]               o_gen_one,
    output logic [30:0]               o_gen_two,
    output logic                      o_done
);

    logic [30:0] r_gen_one;
    logic [30:0] r_gen_two;
    logic [46:0] r_prod_one;
    logic [46:0] r_prod_two;
    logic [31:0] r_fold_one;
    logic [31:0] r_fold_two;
    logic        r_v1;
    logic        r_v2;
    logic        r_v3;
    logic        r_two1;
    logic        r_two2;
    logic [31:0] fold_one;
    logic [31:0] fold_two;
    logic [31:0] red_one;
    logic [31:0] red_two;

    // Fold high part back in: 2^31 is congruent to the fold constant
    assign fold_one = 32'(r_prod_one[30:0])
                    + 32'(r_prod_one[46:31]) * 32'(clcg_pkg::FOLD_ONE);
    assign fold_two = 32'(r_prod_two[30:0])
                    + 32'(r_prod_two[46:31]) * 32'(clcg_pkg::FOLD_TWO);

    // Folded sum stays below twice the modulus: one subtract finishes it
    assign red_one = (r_fold_one >= 32'(clcg_pkg::MOD_ONE))
                   ? r_fold_one - 32'(clcg_pkg::MOD_ONE) : r_fold_one;
    assign red_two = (r_fold_two >= 32'(clcg_pkg::MOD_TWO))
                   ? r_fold_two - 32'(clcg_pkg::MOD_TWO) : r_fold_two;

    // Track the step through the pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_ctrl.start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Multiply and fold stages
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_prod_one <= 47'(r_gen_one) * 47'(clcg_pkg::MUL_ONE);
            r_prod_two <= 47'(r_gen_two) * 47'(clcg_pkg::MUL_TWO);
            r_two1     <= i_ctrl.step_two;
        end
        if (r_v1) begin
            r_fold_one <= fold_one;
            r_fold_two <= fold_two;
            r_two2     <= r_two1;
        end
    end

    // Load from seed or write back the reduced state
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_gen_one <= i_load_value;
            r_gen_two <= i_load_value;
        end else if (r_v2) begin
            r_gen_one <= red_one[30:0];
            if (r_two2) begin
                r_gen_two <= red_two[30:0];
            end
        end
    end

    assign o_gen_one = r_gen_one;
    assign o_gen_two = r_gen_two;
    assign o_done    = r_v3;

endmodule

`default_nettype wire

/* src/combined_lcg_shuffle_rng.sv */
// Path: a request passes the generator step and table read, then the output
//   difference and fraction stages, into the output register; with reseed or
//   a pending init the seed load and warm-up run first. Requests are taken
//   when idle or as the last result is loaded; an output stall holds them off.
// Reset: generators and table are loaded lazily; the first request always
//   reseeds from the seed register (reset value -1) and runs the warm-up.
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng
// Combined two-modulus multiplicative generator behind a shuffle table memory.
// ----------------------------------------------------------------------------
`default_nettype none

module combined_lcg_shuffle_rng #(
    parameter int TABLE_SIZE = clcg_pkg::TABLE_SIZE_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Seed write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_seed_value,
    // Request channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_reseed,
    // Result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [30:0]      o_raw_value,
    output logic [23:0]      o_fraction
);

    localparam int SLOT_W  = $clog2(TABLE_SIZE);
    localparam int RECIP_W = $clog2(TABLE_SIZE + 1);
    localparam int CNT_W   = $clog2(TABLE_SIZE + 8);
    localparam int PROD_W  = 31 + RECIP_W;
    localparam int BOUND_W = 33 + RECIP_W;
    localparam logic [31:0] SLOT_DIV =
        32'(64'(clcg_pkg::RANGE_TOP) / 64'(TABLE_SIZE) + 64'd1);
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(64'h8000_0000 / 64'(SLOT_DIV));
    localparam logic [CNT_W-1:0]   WCNT_INIT = CNT_W'(TABLE_SIZE + 7);
    localparam logic [CNT_W-1:0]   WCNT_TAB  = CNT_W'(TABLE_SIZE);
    localparam logic [SLOT_W-1:0]  TOP_SLOT  = SLOT_W'(TABLE_SIZE - 1);
    localparam logic [RECIP_W:0]   SLOT_LIM  = (RECIP_W + 1)'(TABLE_SIZE);

    clcg_pkg::t_state    r_state;
    clcg_pkg::t_state    n_state;
    clcg_pkg::t_gen_ctrl gen_ctrl;

    logic [31:0]         r_seed;
    logic                r_init_pending;
    logic [31:0]         r_mag;
    logic [CNT_W-1:0]    r_wcnt;
    logic [30:0]         r_last;
    logic [RECIP_W-1:0]  r_q0;
    logic [SLOT_W-1:0]   r_slot;
    logic [30:0]         r_rd;
    logic [23:0]         r_fq0;
    logic [31:0]         r_frem;
    logic                r_out_valid;
    logic [30:0]         r_out_raw;
    logic [23:0]         r_out_frac;
    logic [30:0]         r_table [TABLE_SIZE];

    logic                accept;
    logic                in_ready;
    logic                out_free;
    logic                init_need;
    logic                draw_go;
    logic                warm_done;
    logic                warm_last;
    logic                warm_wr;
    logic                draw_wr;
    logic                tbl_wr;
    logic [SLOT_W-1:0]   tbl_addr;
    logic                rd_en;
    logic                frac_ld;
    logic                out_ld;
    logic [30:0]         gen_one;
    logic [30:0]         gen_two;
    logic                gen_done;
    logic [31:0]         mag_red;
    logic [30:0]         load_val;
    logic [PROD_W-1:0]   q_prod;
    logic [RECIP_W:0]    q_inc;
    logic [BOUND_W-1:0]  q_bound;
    logic                q_ge;
    logic [RECIP_W:0]    slot_full;
    logic [SLOT_W-1:0]   slot;
    logic [31:0]         diff;
    logic [31:0]         diff_wrap;
    logic [30:0]         raw;
    logic [24:0]         frac_inc;
    logic [23:0]         frac;

    // Handshake
    assign o_cfg_ready = 1'b1;
    assign out_free    = ~r_out_valid | ~i_out_stall;
    assign in_ready    = (r_state == clcg_pkg::S_IDLE)
                       | ((r_state == clcg_pkg::S_OUT) & out_free);
    assign o_in_stall  = ~in_ready;
    assign accept      = i_in_valid & in_ready;
    assign init_need   = i_reseed | r_init_pending;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            clcg_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = init_need ? clcg_pkg::S_ABS : clcg_pkg::S_SLOT;
                end
            end
            clcg_pkg::S_ABS:  n_state = clcg_pkg::S_LOAD;
            clcg_pkg::S_LOAD: n_state = clcg_pkg::S_WGO;
            clcg_pkg::S_WGO:  n_state = clcg_pkg::S_WARM;
            clcg_pkg::S_WARM: begin
                if (gen_done && r_wcnt == '0) begin
                    n_state = clcg_pkg::S_DRAW;
                end
            end
            clcg_pkg::S_DRAW: n_state = clcg_pkg::S_SLOT;
            clcg_pkg::S_SLOT: n_state = clcg_pkg::S_WAIT;
            clcg_pkg::S_WAIT: begin
                if (gen_done) begin
                    n_state = clcg_pkg::S_FRAC;
                end
            end
            clcg_pkg::S_FRAC: n_state = clcg_pkg::S_OUT;
            clcg_pkg::S_OUT: begin
                if (out_free) begin
                    if (accept) begin
                        n_state = init_need ? clcg_pkg::S_ABS : clcg_pkg::S_SLOT;
                    end else begin
                        n_state = clcg_pkg::S_IDLE;
                    end
                end
            end
            default: n_state = clcg_pkg::S_IDLE;
        endcase
    end

    // Controller outputs
    always_comb begin
        draw_go   = (accept & ~init_need) | (r_state == clcg_pkg::S_DRAW);
        warm_done = (r_state == clcg_pkg::S_WARM) & gen_done;
        warm_last = warm_done & (r_wcnt == '0);
        warm_wr   = warm_done & (r_wcnt < WCNT_TAB);
        draw_wr   = (r_state == clcg_pkg::S_WAIT) & gen_done;
        rd_en     = (r_state == clcg_pkg::S_SLOT);
        frac_ld   = (r_state == clcg_pkg::S_FRAC);
        out_ld    = (r_state == clcg_pkg::S_OUT) & out_free;
        gen_ctrl.load     = (r_state == clcg_pkg::S_LOAD);
        gen_ctrl.start    = (r_state == clcg_pkg::S_WGO)
                          | (warm_done & ~warm_last) | draw_go;
        gen_ctrl.step_two = draw_go;
        tbl_wr   = warm_wr | draw_wr;
        tbl_addr = warm_wr ? r_wcnt[SLOT_W-1:0] : r_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= clcg_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Generator pair
    clcg_gen_pair u_gen (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (gen_ctrl),
        .i_load_value (load_val),
        .o_gen_one    (gen_one),
        .o_gen_two    (gen_two),
        .o_done       (gen_done)
    );

    // Seed register and pending init flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed         <= 32'hFFFF_FFFF;
            r_init_pending <= 1'b1;
        end else begin
            if (i_cfg_valid) begin
                r_seed <= i_cfg_seed_value;
            end
            if (warm_last) begin
                r_init_pending <= 1'b0;
            end
        end
    end

    // Seed magnitude, reduced once, zero mapped to one
    assign mag_red  = (r_mag >= 32'(clcg_pkg::MOD_ONE))
                    ? r_mag - 32'(clcg_pkg::MOD_ONE) : r_mag;
    assign load_val = (mag_red == '0) ? 31'd1 : mag_red[30:0];

    always_ff @(posedge i_clk) begin
        if (r_state == clcg_pkg::S_ABS) begin
            r_mag <= r_seed[31] ? (~r_seed + 32'd1) : r_seed;
        end
    end

    // Warm-up step counter
    always_ff @(posedge i_clk) begin
        if (r_state == clcg_pkg::S_LOAD) begin
            r_wcnt <= WCNT_INIT;
        end else if (warm_done && !warm_last) begin
            r_wcnt <= r_wcnt - CNT_W'(1);
        end
    end

    // Slot estimate from the previous output by reciprocal, then correct
    assign q_prod    = PROD_W'(r_last) * PROD_W'(RECIP);
    assign q_inc     = (RECIP_W + 1)'(r_q0) + (RECIP_W + 1)'(1);
    assign q_bound   = BOUND_W'(q_inc) * BOUND_W'(SLOT_DIV);
    assign q_ge      = BOUND_W'(r_last) >= q_bound;
    assign slot_full = (RECIP_W + 1)'(r_q0) + (RECIP_W + 1)'(q_ge);
    assign slot      = (slot_full >= SLOT_LIM) ? TOP_SLOT : slot_full[SLOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (draw_go) begin
            r_q0 <= q_prod[PROD_W-1:31];
        end
        if (rd_en) begin
            r_slot <= slot;
        end
    end

    // Shuffle table write port
    always_ff @(posedge i_clk) begin
        if (tbl_wr) begin
            r_table[tbl_addr] <= gen_one;
        end
    end

    // Shuffle table read port
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd <= r_table[slot];
        end
    end

    // New output: table entry at the slot minus second generator, wrapped into range
    assign diff      = {1'b0, r_rd} - {1'b0, gen_two};
    assign diff_wrap = diff + 32'(clcg_pkg::RANGE_TOP);
    assign raw       = (diff[31] || diff == '0) ? diff_wrap[30:0] : diff[30:0];

    always_ff @(posedge i_clk) begin
        if (warm_last) begin
            r_last <= gen_one;
        end else if (draw_wr) begin
            r_last <= raw;
        end
    end

    // Fraction: raw*2^24/MOD_ONE is raw>>7 or one more; remainder decides
    always_ff @(posedge i_clk) begin
        if (frac_ld) begin
            r_fq0  <= r_last[30:7];
            r_frem <= {1'b0, r_last[6:0], 24'd0}
                    + 32'(r_last[30:7]) * 32'(clcg_pkg::FOLD_ONE);
        end
    end

    assign frac_inc = {1'b0, r_fq0} + 25'(r_frem >= 32'(clcg_pkg::MOD_ONE));
    assign frac     = (frac_inc > 25'(clcg_pkg::FRAC_MAX))
                    ? clcg_pkg::FRAC_MAX : frac_inc[23:0];

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ld) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ld) begin
            r_out_raw  <= r_last;
            r_out_frac <= frac;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_raw_value = r_out_raw;
    assign o_fraction  = r_out_frac;

endmodule

`default_nettype wire

/* src/clcg_checker.sv */
// ----------------------------------------------------------------------------
// clcg_checker
// Port-level checks of the combined LCG shuffle generator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module clcg_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        o_in_stall,
    input  wire logic        o_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [30:0] o_raw_value,
    input  wire logic [23:0] o_fraction
);

    // Hold a stalled result
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_raw_value) && $stable(o_fraction))

    // Take one request at a time
    `ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // Raw value stays inside the first modulus range
    `ASSERT_IMPL(a_raw_range, i_clk, i_rst_n, o_out_valid, o_raw_value != 31'd0 && o_raw_value <= 31'd2147483562)

    // Fraction tracks the raw value's top bits, or sits at the clamp
    `ASSERT_IMPL(a_frac_match, i_clk, i_rst_n, o_out_valid, o_fraction == o_raw_value[30:7] || o_fraction == o_raw_value[30:7] + 24'd1 || o_fraction == 24'd16777214)

endmodule

bind combined_lcg_shuffle_rng clcg_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_raw_value (o_raw_value),
    .o_fraction  (o_fraction)
);

`default_nettype wire
